// ----- rtl/jacobi_five_point_stencil_top_macros.svh -----
// Assertion macros for the Jacobi five-point stencil block.
// Used by jacobi_five_point_stencil_top; relies on i_clk and i_rst_n in scope.
`ifndef JACOBI_FIVE_POINT_STENCIL_TOP_MACROS_SVH
`define JACOBI_FIVE_POINT_STENCIL_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define JFPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define JFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/jfps_pkg.sv -----
// Shared constants and types for the Jacobi five-point stencil block.
// No dependencies; used by jfps_cell, the top module and the bench.
package jfps_pkg;

    localparam int GRID         = 1024;
    localparam int SAMPLE_BITS  = 32;
    localparam int COL_W        = $clog2(GRID);
    localparam int IDX_W        = 10;
    localparam int SUM_W        = SAMPLE_BITS + 2;
    localparam int IN_DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SAMPLE_BITS + 2 * IDX_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    // window taps: centre of the current column, then the left neighbor
    localparam int WIN_DEPTH    = 2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic [COL_W-1:0]              t_col;
    typedef logic [IDX_W-1:0]              t_idx;

endpackage

// ----- rtl/jfps_ram.sv -----
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies; holds the line stores of the stencil block.
module jfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last read word until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/jfps_cell.sv -----
// One window cell: holds a sample and passes it to its neighbor on each request.
// Depends on jfps_pkg for the sample type.
module jfps_cell (
    input  logic             i_clk,
    input  logic             i_en,
    input  jfps_pkg::t_sample i_d,
    output jfps_pkg::t_sample o_q
);

    jfps_pkg::t_sample r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/jacobi_five_point_stencil_top.sv -----
// Jacobi five-point stencil sweep over a square grid streamed in raster order.
// Depends on jfps_pkg, jfps_ram, jfps_cell and the assertion macro header.
//
// Usage:
//   s_axis carries one grid sample per request; tuser high marks sample (0,0)
//   of a new grid and restarts the row and column counters. Without it the
//   counters run from (0,0) after reset and wrap after the last sample.
//   m_axis carries the updated interior point (r-1,c) for each sample (r,c)
//   with r >= 2 and 1 <= c <= GRID-2; tlast flags the final interior point.
//   Samples in rows 0 and 1 and in columns 0 and GRID-1 produce no result.
// Pipeline and rate:
//   One sample per cycle while s_axis_tready is high. A taken sample is
//   registered into the add stage with both line store reads; the four-way
//   add then feeds the output register. The rate is set by the single
//   read port of each line store, which is read once per sample.
// Reset:
//   Clears the counters and the pipeline valids; line stores are not cleared
//   and feed results only after two full rows of the current grid are written.
// Stall:
//   A held result keeps its payload; one more result may wait in the add
//   stage, and s_axis_tready drops only when both stages are full.
`include "jacobi_five_point_stencil_top_macros.svh"

module jacobi_five_point_stencil_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [jfps_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [31:0] sample
    input  logic                                 s_axis_tuser,  // [0] grid_start
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] new_value, [41:32] out_row, [51:42] out_col, rest zero
    output logic [jfps_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast   // last_point
);

    localparam jfps_pkg::t_col COL_LAST = jfps_pkg::COL_W'(jfps_pkg::GRID - 1);
    localparam jfps_pkg::t_col COL_EDGE = jfps_pkg::COL_W'(jfps_pkg::GRID - 2);

    logic              acc;
    logic              in_start;
    jfps_pkg::t_sample in_sample;
    jfps_pkg::t_col    cur_row;
    jfps_pkg::t_col    cur_col;
    logic              col_end;
    logic              row_end;
    logic              emit;
    jfps_pkg::t_col    n_row;
    jfps_pkg::t_col    n_col;
    jfps_pkg::t_col    r_row;
    jfps_pkg::t_col    r_col;

    jfps_pkg::t_sample lp_rdata;
    jfps_pkg::t_sample lp2_rdata;
    jfps_pkg::t_sample win_q [jfps_pkg::WIN_DEPTH];

    logic              r_b_valid;
    jfps_pkg::t_sample r_b_down;
    jfps_pkg::t_idx    r_b_row;
    jfps_pkg::t_idx    r_b_col;
    logic              r_b_last;
    jfps_pkg::t_sum    b_sum;
    jfps_pkg::t_sample b_value;
    logic              c_free;
    logic              b_adv;

    logic              r_c_valid;
    jfps_pkg::t_sample r_c_value;
    jfps_pkg::t_idx    r_c_row;
    jfps_pkg::t_idx    r_c_col;
    logic              r_c_last;

    // ---------------- intake and counters ----------------
    assign c_free        = !r_c_valid || m_axis_tready;
    assign b_adv         = r_b_valid && c_free;
    assign s_axis_tready = !r_b_valid || c_free;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign in_start      = s_axis_tuser;
    assign in_sample     = s_axis_tdata[jfps_pkg::SAMPLE_BITS-1:0];

    always_comb begin
        cur_row = in_start ? '0 : r_row;
        cur_col = in_start ? '0 : r_col;
        col_end = (cur_col == COL_LAST);
        row_end = (cur_row == COL_LAST);
        n_col   = col_end ? '0 : cur_col + jfps_pkg::COL_W'(1);
        n_row   = col_end ? (row_end ? '0 : cur_row + jfps_pkg::COL_W'(1)) : cur_row;
        emit    = (cur_row >= jfps_pkg::COL_W'(2)) && (cur_col != '0)
                  && (cur_col <= COL_EDGE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ---------------- line stores ----------------
    // Row r-1: read one column ahead, so the word held at the next request
    // is that request's centre; write the new sample behind it.
    jfps_ram #(
        .WIDTH (jfps_pkg::SAMPLE_BITS),
        .DEPTH (jfps_pkg::GRID)
    ) u_line_prev (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (cur_col),
        .i_wdata (in_sample),
        .i_re    (acc),
        .i_raddr (n_col),
        .o_rdata (lp_rdata)
    );

    // Row r-2: the centre drops down into it; read-first gives the old word.
    jfps_ram #(
        .WIDTH (jfps_pkg::SAMPLE_BITS),
        .DEPTH (jfps_pkg::GRID)
    ) u_line_prev2 (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (cur_col),
        .i_wdata (lp_rdata),
        .i_re    (acc),
        .i_raddr (cur_col),
        .o_rdata (lp2_rdata)
    );

    // ---------------- window chain ----------------
    for (genvar g = 0; g < jfps_pkg::WIN_DEPTH; g++) begin : g_win
        if (g == 0) begin : g_head
            jfps_cell u_cell (
                .i_clk (i_clk),
                .i_en  (acc),
                .i_d   (lp_rdata),
                .o_q   (win_q[g])
            );
        end else begin : g_link
            jfps_cell u_cell (
                .i_clk (i_clk),
                .i_en  (acc),
                .i_d   (win_q[g-1]),
                .o_q   (win_q[g])
            );
        end
    end

    // ---------------- add stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (acc) begin
            r_b_valid <= emit;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_down <= in_sample;
            r_b_row  <= jfps_pkg::IDX_W'(cur_row - jfps_pkg::COL_W'(1));
            r_b_col  <= jfps_pkg::IDX_W'(cur_col);
            r_b_last <= row_end && (cur_col == COL_EDGE);
        end
    end

    // up, down, left, right; floor of a quarter by arithmetic shift
    always_comb begin
        b_sum   = jfps_pkg::SUM_W'(lp2_rdata)
                + jfps_pkg::SUM_W'(r_b_down)
                + jfps_pkg::SUM_W'(win_q[jfps_pkg::WIN_DEPTH-1])
                + jfps_pkg::SUM_W'(lp_rdata);
        b_value = b_sum[jfps_pkg::SUM_W-1:2];
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (b_adv) begin
            r_c_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_c_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_c_value <= b_value;
            r_c_row   <= r_b_row;
            r_c_col   <= r_b_col;
            r_c_last  <= r_b_last;
        end
    end

    assign m_axis_tvalid = r_c_valid;
    assign m_axis_tdata  = jfps_pkg::OUT_DATA_W'({r_c_col, r_c_row, r_c_value});
    assign m_axis_tlast  = r_c_last;

    // ---------------- assertions ----------------
    `JFPS_ASSERT_NEXT(a_hold_add_stage, r_b_valid && r_c_valid && !m_axis_tready, r_b_valid, "add stage dropped a stalled result")
    `JFPS_ASSERT_NOW(a_col_range, 1'b1, r_col <= COL_LAST, "column counter out of range")
    `JFPS_ASSERT_NOW(a_last_col, m_axis_tvalid && m_axis_tlast, r_c_col == jfps_pkg::IDX_W'(jfps_pkg::GRID - 2), "last point flagged off the last interior column")
    `JFPS_ASSERT_NEXT(a_col_wrap, acc && !in_start && (cur_col == COL_LAST), r_col == '0, "column counter did not wrap")

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for jacobi_five_point_stencil_top: raster grids in, updated
// interior points out, each compared field by field with an in-bench stencil predictor.
// Depends on jfps_pkg and the block's RTL only.
module tb;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned EDGE_RUN    = 100;

    typedef enum {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_CORNER} t_fill_kind;
    typedef enum {SINK_OPEN, SINK_MOSTLY, SINK_SPARSE, SINK_TOGGLE} t_sink_pattern;

    typedef struct {
        jfps_pkg::t_sample value;
        jfps_pkg::t_idx    row;
        jfps_pkg::t_idx    col;
        logic              last;
    } t_stencil_point;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [jfps_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [jfps_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;

    jacobi_five_point_stencil_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] sample
        .s_axis_tuser  (s_axis_tuser),   // [0] grid_start
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] new_value, [41:32] out_row, [51:42] out_col
        .m_axis_tlast  (m_axis_tlast)    // last_point
    );

    always #6 i_clk = ~i_clk;

    // predictor state: two rows of history, the left tap and the raster position
    jfps_pkg::t_sample row_above[jfps_pkg::GRID];
    jfps_pkg::t_sample row_prev[jfps_pkg::GRID];
    jfps_pkg::t_sample left_tap;
    int unsigned       cur_row;
    int unsigned       cur_col;

    t_stencil_point predicted_points[$];
    int unsigned    stencil_mismatches;
    int unsigned    cycle_count;

    bit            pace_traffic = 1'b1;
    int unsigned   burst_left;
    int unsigned   hold_req;
    int unsigned   hold_seen;
    int unsigned   hold_left;
    t_sink_pattern sink_pattern = SINK_OPEN;
    int unsigned   pattern_left;

    initial begin
        for (int i = 0; i < jfps_pkg::GRID; i++) begin
            row_above[i] = '0;
            row_prev[i]  = '0;
        end
        left_tap = '0;
        cur_row  = 0;
        cur_col  = 0;
    end

    function automatic void predict_stencil(input jfps_pkg::t_sample smp, input bit start);
        jfps_pkg::t_sample centre;
        jfps_pkg::t_sum    total;
        t_stencil_point    pt;
        if (start) begin
            cur_row  = 0;
            cur_col  = 0;
            left_tap = '0;
        end
        centre = row_prev[cur_col];
        if (cur_row >= 2 && cur_col >= 1 && cur_col <= jfps_pkg::GRID - 2) begin
            total = jfps_pkg::t_sum'(row_above[cur_col]) + jfps_pkg::t_sum'(smp)
                  + jfps_pkg::t_sum'(left_tap) + jfps_pkg::t_sum'(row_prev[cur_col + 1]);
            pt.value = jfps_pkg::t_sample'(total >>> 2);
            pt.row   = jfps_pkg::t_idx'(cur_row - 1);
            pt.col   = jfps_pkg::t_idx'(cur_col);
            pt.last  = (cur_row == jfps_pkg::GRID - 1) && (cur_col == jfps_pkg::GRID - 2);
            predicted_points.push_back(pt);
        end
        row_above[cur_col] = centre;
        row_prev[cur_col]  = smp;
        left_tap           = centre;
        cur_col++;
        if (cur_col >= jfps_pkg::GRID) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= jfps_pkg::GRID)
                cur_row = 0;
        end
    endfunction

    function automatic jfps_pkg::t_sample fill_value(input t_fill_kind fill);
        case (fill)
            FILL_MAX: return 32'h7FFF_FFFF;
            FILL_MIN: return 32'h8000_0000;
            FILL_CORNER: begin
                case ($urandom_range(0, 7))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    4: return 32'h0000_0001;
                    5: return 32'hFFFF_FFFE;
                    6: return 32'h4000_0000;
                    default: return 32'hC000_0001;
                endcase
            end
            default: return jfps_pkg::t_sample'($urandom());
        endcase
    endfunction

    // Offer one request and hold it until taken; valid stays high unless pacing adds a gap.
    task automatic send_sample(input jfps_pkg::t_sample value, input bit start);
        int unsigned gap;
        if (pace_traffic) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 48);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_stencil(value, start);
    endtask

    task automatic send_run(input int unsigned count, input bit start_first,
                            input t_fill_kind fill);
        for (int unsigned i = 0; i < count; i++)
            send_sample(fill_value(fill), start_first && i == 0);
    endtask

    task automatic sender_idle();
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (predicted_points.size() != 0);
    endtask

    // No grid start after reset: the first two rows, each led by runs of extreme values.
    task automatic test_rows_without_start();
        repeat (2) begin
            send_run(EDGE_RUN, 1'b0, FILL_MAX);
            send_run(EDGE_RUN, 1'b0, FILL_MIN);
            send_run(jfps_pkg::GRID - 2 * EDGE_RUN, 1'b0, FILL_CORNER);
        end
    endtask

    // First result row under the extreme rows: largest and smallest neighbor sums.
    task automatic test_extreme_values();
        send_run(EDGE_RUN, 1'b0, FILL_MAX);
        send_run(EDGE_RUN, 1'b0, FILL_MIN);
    endtask

    // Hold the sink long enough that the block fills and drops s_axis_tready.
    task automatic test_output_backpressure();
        hold_req++;
        send_run(300, 1'b0, FILL_RANDOM);
    endtask

    task automatic test_drain_pause();
        send_run(EDGE_RUN, 1'b0, FILL_CORNER);
        sender_idle();
        wait_drained();
        send_run(EDGE_RUN, 1'b0, FILL_CORNER);
    endtask

    // Back to back through the right edge of the row and into the next one.
    task automatic test_row_edge();
        pace_traffic = 1'b0;
        send_run(jfps_pkg::GRID - cur_col + 40, 1'b0, FILL_RANDOM);
        pace_traffic = 1'b1;
    endtask

    // Restart in the middle of a result row; the new grid gives no result yet.
    task automatic test_midrow_restart();
        send_run(60, 1'b1, FILL_RANDOM);
    endtask

    // Sink: a long hold on request, ready if unpaced, else patterns that change every so often.
    always @(posedge i_clk) begin : sink_pacing
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!pace_traffic) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                sink_pattern = t_sink_pattern'($urandom_range(0, 3));
                pattern_left = $urandom_range(32, 256);
            end
            pattern_left--;
            case (sink_pattern)
                SINK_OPEN:   m_axis_tready <= 1'b1;
                SINK_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:     m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    function automatic void note_mismatch(input string what, input t_stencil_point want,
                                          input t_stencil_point got);
        stencil_mismatches++;
        if (stencil_mismatches <= MAX_REPORTS)
            $display("%s: expected value %0d row %0d col %0d last %0b,",
                     what, want.value, want.row, want.col, want.last,
                     " got value %0d row %0d col %0d last %0b",
                     got.value, got.row, got.col, got.last);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_stencil_point got;
        t_stencil_point want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.value = m_axis_tdata[jfps_pkg::SAMPLE_BITS-1:0];
            got.row   = m_axis_tdata[jfps_pkg::SAMPLE_BITS +: jfps_pkg::IDX_W];
            got.col   = m_axis_tdata[jfps_pkg::SAMPLE_BITS + jfps_pkg::IDX_W +: jfps_pkg::IDX_W];
            got.last  = m_axis_tlast;
            if (predicted_points.size() == 0) begin
                want = '{default: '0};
                note_mismatch("unexpected result", want, got);
            end else begin
                want = predicted_points.pop_front();
                if (got.value !== want.value || got.row !== want.row ||
                    got.col !== want.col || got.last !== want.last)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_rows_without_start();
        test_extreme_values();
        test_output_backpressure();
        test_drain_pause();
        test_row_edge();
        test_midrow_restart();
        sender_idle();
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (stencil_mismatches == 0 && predicted_points.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
